[rtl/core/cil_pkg.sv]
// Package for the compacting item list: sizes, request and status codes,
// and the command bundle broadcast to the storage cells. No dependencies.
package cil_pkg;

  localparam int CAPACITY   = 64;
  localparam int ITEM_WIDTH = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int GROUP      = 8;
  localparam int NGROUP     = (CAPACITY + GROUP - 1) / GROUP;

  localparam logic [2:0] ACT_APPEND    = 3'd0;
  localparam logic [2:0] ACT_SET       = 3'd1;
  localparam logic [2:0] ACT_GET       = 3'd2;
  localparam logic [2:0] ACT_READ_LAST = 3'd3;
  localparam logic [2:0] ACT_REMOVE    = 3'd4;
  localparam logic [2:0] ACT_DROP_LAST = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef logic [ITEM_WIDTH-1:0] item_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    item_t            wr_val;
    logic             sh_en;
    logic [IDX_W-1:0] sh_idx;
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
  } cil_cmd_t;

endpackage

[rtl/core/compacting_item_list.sv]
// Compacting item list: a row of cells, one per slot, that shift down on remove.
// Results pass the read-tree group register, then the output register.
// Throughput: one request per cycle while out_ready is high; the read OR tree spans two registers.
// Reset: synchronous active-low rst_n clears the count and all valid flags;
// slot contents are not reset and are only read below the count.
module compacting_item_list (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [2:0]                in_action,
  input  logic [cil_pkg::IDX_W-1:0] in_position,
  input  cil_pkg::item_t            in_item_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output cil_pkg::item_t            out_read_value,
  output logic                      out_read_valid,
  output logic [1:0]                out_status,
  output logic [cil_pkg::CNT_W-1:0] out_item_count
);
  import cil_pkg::*;

  logic             in_fire;
  logic             s_adv;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  cil_cmd_t         cmd;
  logic             rv_nxt;
  logic [1:0]       st_nxt;

  item_t            slot_q  [CAPACITY];
  item_t            cell_rd [CAPACITY];
  item_t            grp_or  [NGROUP];

  logic             s_valid_r;
  item_t            s_grp_r [NGROUP];
  logic             s_rv_r;
  logic [1:0]       s_st_r;
  logic [CNT_W-1:0] s_cnt_r;
  item_t            tree_or;

  logic             out_valid_r;
  item_t            out_value_r;
  logic             out_rv_r;
  logic [1:0]       out_st_r;
  logic [CNT_W-1:0] out_cnt_r;

  logic [31:0]      pos_w;
  logic [31:0]      cnt_w;
  logic [CNT_W-1:0] last_cnt;

  assign s_adv    = !out_valid_r || out_ready;
  assign in_ready = !s_valid_r || s_adv;
  assign in_fire  = in_valid && in_ready;

  assign pos_w    = 32'(in_position);
  assign cnt_w    = 32'(count_r);
  assign last_cnt = count_r - CNT_W'(1);

  // decode the request into a cell command, status and next count
  always_comb begin
    cmd        = '0;
    cmd.wr_val = in_item_value;
    count_nxt  = count_r;
    rv_nxt     = 1'b0;
    st_nxt     = ST_OK;
    case (in_action)
      ACT_APPEND: begin
        if (cnt_w >= 32'(CAPACITY)) begin
          st_nxt = ST_FULL;
        end else begin
          cmd.wr_en  = in_fire;
          cmd.wr_idx = count_r[IDX_W-1:0];
          count_nxt  = count_r + CNT_W'(1);
        end
      end
      ACT_SET: begin
        if (pos_w < cnt_w) begin
          cmd.wr_en  = in_fire;
          cmd.wr_idx = in_position;
        end else begin
          st_nxt = ST_RANGE;
        end
      end
      ACT_GET: begin
        if (pos_w < cnt_w) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_idx = in_position;
          rv_nxt     = 1'b1;
        end else begin
          st_nxt = ST_RANGE;
        end
      end
      ACT_READ_LAST: begin
        if (count_r != '0) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_idx = last_cnt[IDX_W-1:0];
          rv_nxt     = 1'b1;
        end else begin
          st_nxt = ST_RANGE;
        end
      end
      ACT_REMOVE: begin
        if (pos_w < cnt_w) begin
          cmd.sh_en  = in_fire;
          cmd.sh_idx = in_position;
          count_nxt  = last_cnt;
        end else begin
          st_nxt = ST_RANGE;
        end
      end
      ACT_DROP_LAST: begin
        if (count_r != '0) begin
          count_nxt = last_cnt;
        end else begin
          st_nxt = ST_RANGE;
        end
      end
      default: begin
        st_nxt = ST_RANGE;
      end
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    item_t right_value;
    if (i < CAPACITY - 1) begin : g_mid
      assign right_value = slot_q[i+1];
    end else begin : g_end
      assign right_value = '0;
    end
    cil_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .cell_idx   (IDX_W'(i)),
      .right_value(right_value),
      .slot_value (slot_q[i]),
      .rd_value   (cell_rd[i])
    );
  end

  // first level of the read tree: OR within each group of cells
  always_comb begin
    for (int g = 0; g < NGROUP; g++) begin
      grp_or[g] = '0;
      for (int k = 0; k < GROUP; k++) begin
        if (g * GROUP + k < CAPACITY) begin
          grp_or[g] = grp_or[g] | cell_rd[g*GROUP+k];
        end
      end
    end
  end

  // second level: OR across the registered groups
  always_comb begin
    tree_or = '0;
    for (int g = 0; g < NGROUP; g++) begin
      tree_or = tree_or | s_grp_r[g];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      s_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        count_r <= count_nxt;
      end
      if (in_ready) begin
        s_valid_r <= in_fire;
      end
      if (s_adv) begin
        out_valid_r <= s_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s_grp_r <= grp_or;
      s_rv_r  <= rv_nxt;
      s_st_r  <= st_nxt;
      s_cnt_r <= count_nxt;
    end
    if (s_adv && s_valid_r) begin
      out_value_r <= tree_or;
      out_rv_r    <= s_rv_r;
      out_st_r    <= s_st_r;
      out_cnt_r   <= s_cnt_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_value_r;
  assign out_read_valid = out_rv_r;
  assign out_status     = out_st_r;
  assign out_item_count = out_cnt_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= 32'(CAPACITY))
    else $error("item count above capacity");

  a_count_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> $stable(count_r))
    else $error("item count changed without a request");

  a_read_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_rv_r |-> out_st_r == ST_OK)
    else $error("read result flagged with error status");

  a_no_stage_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    s_valid_r && !s_adv |=> s_valid_r && $stable(s_cnt_r))
    else $error("read stage overwritten while stalled");
`endif

endmodule

[rtl/core/cil_cell.sv]
// One storage cell of the list: holds a single slot, loads on a write hit,
// takes its right neighbor's word on a remove at or below it.
// Depends on cil_pkg.
module cil_cell (
  input  logic                         clk,
  input  cil_pkg::cil_cmd_t            cmd,
  input  logic [cil_pkg::IDX_W-1:0]    cell_idx,
  input  cil_pkg::item_t               right_value,
  output cil_pkg::item_t               slot_value,
  output cil_pkg::item_t               rd_value
);
  import cil_pkg::*;

  item_t slot_r;
  item_t slot_nxt;

  always_comb begin
    slot_nxt = slot_r;
    if (cmd.wr_en && (cmd.wr_idx == cell_idx)) begin
      slot_nxt = cmd.wr_val;
    end else if (cmd.sh_en && (cell_idx >= cmd.sh_idx)) begin
      slot_nxt = right_value;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  assign slot_value = slot_r;
  // drive zero unless addressed so the read tree can simply OR
  assign rd_value = (cmd.rd_en && (cmd.rd_idx == cell_idx)) ? slot_r : '0;

endmodule
